/* rtl/core/vrpm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vrpm_pkg
// Shared types and constants of the vertical resample pixel MAC.
// ----------------------------------------------------------------------------
package vrpm_pkg;

  localparam int unsigned ChanWidth   = 8;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned SumWidth    = 32;
  localparam int unsigned NumChan     = 4;
  localparam int unsigned InDataWidth  = NumChan * ChanWidth + WeightWidth;
  localparam int unsigned OutDataWidth = NumChan * ChanWidth;

  // Rounding bias that every channel sum starts from.
  localparam logic [SumWidth-1:0] SumBias = 32'h0000_0080;

  // Channel order in the sum vector and in tdata.
  localparam int unsigned ChAlpha = 0;
  localparam int unsigned ChRed   = 1;
  localparam int unsigned ChGreen = 2;
  localparam int unsigned ChBlue  = 3;

  typedef logic [NumChan-1:0][SumWidth-1:0]  sum_vec_t;
  typedef logic [NumChan-1:0][ChanWidth-1:0] pixel_t;

  // Per-lane accumulate control.
  typedef struct packed {
    logic advance;  // take the registered tap into the sum
    logic restart;  // last tap: reload the bias instead
  } lane_ctrl_t;

endpackage : vrpm_pkg
`default_nettype wire

/* rtl/core/vrpm_mac_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vrpm_mac_lane
// One channel multiply-accumulate: sum += channel * weight, modulo 2^32.
// ----------------------------------------------------------------------------
module vrpm_mac_lane (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire  vrpm_pkg::lane_ctrl_t              ctrl,
  input  wire  [vrpm_pkg::ChanWidth-1:0]          channel,
  input  wire  signed [vrpm_pkg::WeightWidth-1:0] weight,
  output logic [vrpm_pkg::SumWidth-1:0]           sum,
  output logic [vrpm_pkg::SumWidth-1:0]           sum_next
);
  import vrpm_pkg::*;

  localparam int unsigned ProdWidth = ChanWidth + 1 + WeightWidth;

  logic signed [ProdWidth-1:0] prod;

  assign prod     = $signed({1'b0, channel}) * weight;
  assign sum_next = sum + {{(SumWidth-ProdWidth){prod[ProdWidth-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= SumBias;
    end else if (ctrl.advance) begin
      sum <= ctrl.restart ? SumBias : sum_next;
    end
  end

endmodule : vrpm_mac_lane
`default_nettype wire

/* rtl/core/vrpm_clamp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vrpm_clamp
// Normalize the four sums (arithmetic shift by 8) and clamp each channel.
// ----------------------------------------------------------------------------
module vrpm_clamp (
  input  wire vrpm_pkg::sum_vec_t sums,
  input  wire                     signed_mode,
  output vrpm_pkg::pixel_t        pixel
);
  import vrpm_pkg::*;

  localparam logic [ChanWidth-1:0] ChanMax = {ChanWidth{1'b1}};

  // Negative clamps to zero, otherwise shift down and limit to hi.
  function automatic logic [ChanWidth-1:0] norm_clamp(
    input logic [SumWidth-1:0]  v,
    input logic [ChanWidth-1:0] hi
  );
    logic [SumWidth-10:0] t;
    t = v[SumWidth-2:8];
    if (v[SumWidth-1]) begin
      norm_clamp = '0;
    end else if (t > {{(SumWidth-9-ChanWidth){1'b0}}, hi}) begin
      norm_clamp = hi;
    end else begin
      norm_clamp = t[ChanWidth-1:0];
    end
  endfunction

  logic [ChanWidth-1:0] alpha;
  logic [ChanWidth-1:0] limit;

  always_comb begin
    alpha = norm_clamp(sums[ChAlpha], ChanMax);
    limit = signed_mode ? alpha : ChanMax;
    pixel[ChAlpha] = alpha;
    pixel[ChRed]   = norm_clamp(sums[ChRed], limit);
    pixel[ChGreen] = norm_clamp(sums[ChGreen], limit);
    pixel[ChBlue]  = norm_clamp(sums[ChBlue], limit);
  end

endmodule : vrpm_clamp
`default_nettype wire

/* rtl/core/vertical_resample_pixel_mac.sv */
`default_nettype none
// A last tap moves from the input register into the output register once it is free.
// Throughput: one tap per cycle while no last tap waits on a held result; the four
//   lane MACs plus clamp are combinational between the input and output registers.
// A held result stalls only last taps; other taps keep flowing into the sums.
// Reset (rst, synchronous, active high): sums reload the bias 128, both
//   registers empty, signed_mode returns to 0.
// ----------------------------------------------------------------------------
// vertical_resample_pixel_mac
// Vertical polyphase resample MAC for premultiplied ARGB pixels: accumulate
// weighted taps per channel and emit one clamped pixel on the last tap.
// ----------------------------------------------------------------------------
module vertical_resample_pixel_mac (
  input  wire                                  clk,
  input  wire                                  rst,
  // configuration
  input  wire                                  cfg_we,
  input  wire                                  cfg_wdata,    // signed_mode
  // tap input
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // alpha_in[7:0], red_in[15:8], green_in[23:16], blue_in[31:24],
  // tap_weight[47:32]
  input  wire  [vrpm_pkg::InDataWidth-1:0]     s_axis_tdata,
  input  wire                                  s_axis_tlast, // last_tap
  // pixel output
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // alpha_out[7:0], red_out[15:8], green_out[23:16], blue_out[31:24]
  output logic [vrpm_pkg::OutDataWidth-1:0]    m_axis_tdata
);
  import vrpm_pkg::*;

  // Configuration register.
  logic signed_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_we) begin
      signed_mode <= cfg_wdata;
    end
  end

  // Input register.
  logic                         in_valid;
  logic                         in_last;
  pixel_t                       in_pixel;
  logic signed [WeightWidth-1:0] in_weight;

  logic       advance;
  lane_ctrl_t lane_ctrl;

  // A last tap needs a free output slot; other taps never wait.
  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_pixel  <= s_axis_tdata[OutDataWidth-1:0];
      in_weight <= $signed(s_axis_tdata[InDataWidth-1:OutDataWidth]);
      in_last   <= s_axis_tlast;
    end
  end

  // Channel lanes.
  sum_vec_t sums;
  sum_vec_t sums_next;

  assign lane_ctrl.advance = advance;
  assign lane_ctrl.restart = in_last;

  for (genvar g = 0; g < NumChan; g++) begin : g_lane
    vrpm_mac_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl),
      .channel  (in_pixel[g]),
      .weight   (in_weight),
      .sum      (sums[g]),
      .sum_next (sums_next[g])
    );
  end

  // Normalize and clamp the final sums of the pixel.
  pixel_t result;

  vrpm_clamp u_clamp (
    .sums        (sums_next),
    .signed_mode (signed_mode),
    .pixel       (result)
  );

  // Output register: load on a last tap, drop on a completed transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_axis_tdata <= result;
    end
  end

  // Assertions.
  a_restart_bias: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (sums[ChAlpha] == SumBias && sums[ChRed] == SumBias &&
                              sums[ChGreen] == SumBias && sums[ChBlue] == SumBias))
    else $error("sums not reloaded with bias after last tap");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> m_axis_tvalid)
    else $error("last tap did not produce a result");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && in_last && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a held result");

  a_hold_sums: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(sums))
    else $error("sums changed without a tap");

endmodule : vertical_resample_pixel_mac
`default_nettype wire
